@@ sv/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg - shared types and constants for differential drive odometry
// Fixed point constants, CORDIC angle table, sequencer states and helpers.
// ----------------------------------------------------------------------------
package odo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_RADIUS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_WIDTH  = 8'd1;

   localparam logic [15:0] RADIUS_RESET = 16'd3277;
   localparam logic [15:0] TRACK_RESET  = 16'd9830;

   localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
   localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [25:0] FULL_TURN_Q16    = 26'sd23592960;
   localparam logic signed [25:0] HALF_TURN_Q16    = 26'sd11796480;
   localparam logic signed [25:0] QUARTER_TURN_Q16 = 26'sd5898240;

   // full turn is 45 * 2^19: bias keeps the 13 bit turn index positive
   localparam logic [13:0] MOD_BIAS  = 14'd4140;
   localparam logic [14:0] RECIP_45  = 15'd23302;
   localparam logic [13:0] MOD_BASE  = 14'd45;

   typedef logic signed [31:0] atan_table_type [CORDIC_STEPS];

   typedef enum logic [4:0] {
      S_IDLE, S_LMR, S_LAK, S_LBK, S_LFIN, S_RAK, S_RBK, S_RFIN, S_SUM,
      S_DIV, S_HMUL, S_HFIN, S_ANG1, S_ANG2, S_ROT, S_XMUL, S_YMUL, S_YFIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic atan_table_type build_atan_table();
      atan_table_type t;
      logic [63:0] k;
      logic [63:0] s;
      logic [63:0] c;
      k = 64'd961263669 << 20;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         case (i)
            0: t[i] = 32'sd754974720;
            1: t[i] = 32'sd445687602;
            2: t[i] = 32'sd235489088;
            3: t[i] = 32'sd119537938;
            4: t[i] = 32'sd60000934;
            5: t[i] = 32'sd30029717;
            6: t[i] = 32'sd15018523;
            default: begin
               s = k >> i;
               c = (3 * i < 64) ? (k >> (3 * i)) / 3 : 64'd0;
               t[i] = 32'((s - c + (64'd1 << 19)) >> 20);
            end
         endcase
      end
      return t;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan_table();

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

@@ sv/odo_if.sv @@
// ----------------------------------------------------------------------------
// odo_if - handshake channels of the odometry block
// Request, response and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface odo_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] left_count;
   logic signed [31:0] right_count;
   modport source (output valid, mode, left_count, right_count, input ready);
   modport sink   (input valid, mode, left_count, right_count, output ready);
endinterface

interface odo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;
   logic signed [31:0] travelled;
   modport source (output valid, pos_x, pos_y, heading, travelled, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, travelled, output ready);
endinterface

interface odo_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/differential_drive_odometry_top.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry_top - wheel odometry for a two wheel robot
// A sequencer drives one shared 34 x 34 multiplier for a measure word: the
// two wheel distances and their sum, a wait on the radix 2 divider for the
// heading, heading scale and angle reduction, one shared CORDIC stage for
// all 16 steps, then the position step and the output. A heading that
// saturates skips the divider and the scale. A clear word goes straight to
// the output state with a zero pose. The block is not ready while a word is
// in work; a finished response waits in an output register, and a stalled
// response holds the block in its output state.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top
   import odo_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   odo_req_if.sink   req,
   odo_rsp_if.source rsp,
   odo_csr_if.sink   csr
);

   state_type state_ff, state_in;

   logic [15:0] radius_ff, track_ff;
   logic signed [31:0] cnt_l_ff, cnt_l_in, cnt_r_ff, cnt_r_in;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;
   logic [31:0] lo_ff, lo_in;
   logic [42:0] acc_ff, acc_in;
   logic signed [45:0] dist_l_ff, dist_l_in, dist_r_ff, dist_r_in;
   logic signed [31:0] trav_ff, trav_in, head_ff, head_in;
   logic neg_ff, neg_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic flip_ff, flip_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in, prev_d_ff, prev_d_in;
   logic signed [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [31:0] out_h_ff, out_h_in, out_t_ff, out_t_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [31:0] mag_l, mag_r;
   logic [59:0] lo_sum;
   logic [44:0] dist_v;
   logic signed [45:0] dist_s;
   logic signed [46:0] sum_s, sum_h, half_s, diff_s;
   logic [45:0] diff_mag;
   logic [15:0] w_eff;
   logic [61:0] numer;
   logic        ovf;
   logic        div_start;
   div_status_type div_status;
   logic [31:0] quotient;
   logic [54:0] hd_sum;
   logic signed [39:0] hd_v;
   logic [13:0] ang_x, rem14;
   logic [7:0]  quo;
   logic signed [25:0] r0, r1, r2;
   logic        fl;
   logic signed [33:0] shx, shy, atan_v, cs, sn;
   logic signed [32:0] dd;
   logic signed [67:0] rnd;
   logic signed [67:0] step_v;
   logic        cur_neg;

   odo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer_hi (numer[47:32]),
      .numer_lo (numer[31:0]),
      .divisor  (w_eff),
      .status   (div_status),
      .quotient (quotient)
   );

   assign mag_l = cnt_l_ff[31] ? 32'(~cnt_l_ff + 32'sd1) : 32'(cnt_l_ff);
   assign mag_r = cnt_r_ff[31] ? 32'(~cnt_r_ff + 32'sd1) : 32'(cnt_r_ff);
   assign w_eff = (track_ff == 16'd0) ? 16'd1 : track_ff;
   assign cs    = flip_ff ? -cx_ff : cx_ff;
   assign sn    = flip_ff ? -cy_ff : cy_ff;
   assign dd    = 33'(trav_ff) - 33'(prev_d_ff);
   assign ang_x = 14'($signed(head_ff[31:19])) + MOD_BIAS;

   always_comb begin
      state_in     = state_ff;
      cnt_l_in     = cnt_l_ff;
      cnt_r_in     = cnt_r_ff;
      lo_in        = lo_ff;
      acc_in       = acc_ff;
      dist_l_in    = dist_l_ff;
      dist_r_in    = dist_r_ff;
      trav_in      = trav_ff;
      head_in      = head_ff;
      neg_in       = neg_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      step_in      = step_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_d_in    = prev_d_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_h_in     = out_h_ff;
      out_t_in     = out_t_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      cur_neg      = (state_ff == S_LFIN) ? cnt_l_ff[31] : cnt_r_ff[31];

      lo_sum   = {1'b0, prod_ff[58:0]} + 60'h80000000;
      dist_v   = 45'(acc_ff) + 45'(lo_sum[59:32]);
      dist_s   = cur_neg ? -$signed({1'b0, dist_v}) : $signed({1'b0, dist_v});
      sum_s    = 47'(dist_l_ff) + 47'(dist_r_ff);
      sum_h    = sum_s + $signed({46'd0, sum_s[46]});
      half_s   = sum_h >>> 1;
      diff_s   = 47'(dist_r_ff) - 47'(dist_l_ff);
      diff_mag = diff_s[46] ? 46'(-diff_s) : 46'(diff_s);
      numer    = {diff_mag, 16'd0} + 62'(w_eff >> 1);
      ovf      = numer[61:32] >= 30'(w_eff);
      hd_sum   = {1'b0, prod_ff[53:0]} + 55'h8000;
      hd_v     = neg_ff ? -$signed({1'b0, hd_sum[54:16]}) : $signed({1'b0, hd_sum[54:16]});
      quo      = prod_ff[27:20];
      rem14    = ang_x - 14'(quo) * MOD_BASE;
      r0       = $signed({1'b0, rem14[5:0], head_ff[18:0]});
      r1       = (r0 >= HALF_TURN_Q16) ? r0 - FULL_TURN_Q16 : r0;
      fl       = 1'b0;
      r2       = r1;
      if (r1 > QUARTER_TURN_Q16) begin
         r2 = r1 - HALF_TURN_Q16;
         fl = 1'b1;
      end else if (r1 < -QUARTER_TURN_Q16) begin
         r2 = r1 + HALF_TURN_Q16;
         fl = 1'b1;
      end
      shx      = cx_ff >>> step_ff;
      shy      = cy_ff >>> step_ff;
      atan_v   = 34'(ATAN_TABLE[step_ff]);
      rnd      = prod_ff + 68'sd536870912;
      step_v   = rnd >>> 30;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cnt_l_in = req.left_count;
               cnt_r_in = req.right_count;
               if (req.mode) begin
                  nx_in    = '0;
                  ny_in    = '0;
                  head_in  = '0;
                  trav_in  = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_LMR;
               end
            end
         end
         S_LMR: begin
            mul_a    = $signed({2'b00, mag_l});
            mul_b    = $signed({18'd0, radius_ff});
            state_in = S_LAK;
         end
         S_LAK, S_RAK: begin
            mul_a    = $signed({18'd0, prod_ff[47:32]});
            mul_b    = $signed({7'd0, DEG2RAD_Q32});
            lo_in    = prod_ff[31:0];
            state_in = (state_ff == S_LAK) ? S_LBK : S_RBK;
         end
         S_LBK, S_RBK: begin
            acc_in   = prod_ff[42:0];
            mul_a    = $signed({2'b00, lo_ff});
            mul_b    = $signed({7'd0, DEG2RAD_Q32});
            state_in = (state_ff == S_LBK) ? S_LFIN : S_RFIN;
         end
         S_LFIN: begin
            dist_l_in = dist_s;
            mul_a     = $signed({2'b00, mag_r});
            mul_b     = $signed({18'd0, radius_ff});
            state_in  = S_RAK;
         end
         S_RFIN: begin
            dist_r_in = dist_s;
            state_in  = S_SUM;
         end
         S_SUM: begin
            trav_in = sat32(64'(half_s));
            neg_in  = diff_s[46];
            if (ovf) begin
               head_in  = diff_s[46] ? 32'sh80000000 : 32'sh7fffffff;
               state_in = S_ANG1;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) state_in = S_HMUL;
         end
         S_HMUL: begin
            mul_a    = $signed({2'b00, quotient});
            mul_b    = $signed({12'd0, RAD2DEG_Q16});
            state_in = S_HFIN;
         end
         S_HFIN: begin
            head_in  = sat32(64'(hd_v));
            state_in = S_ANG1;
         end
         S_ANG1: begin
            mul_a    = $signed({20'd0, ang_x});
            mul_b    = $signed({19'd0, RECIP_45});
            state_in = S_ANG2;
         end
         S_ANG2: begin
            cx_in    = CORDIC_GAIN_Q30;
            cy_in    = '0;
            cz_in    = 34'(r2) <<< 8;
            flip_in  = fl;
            step_in  = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - shy;
               cy_in = cy_ff + shx;
               cz_in = cz_ff - atan_v;
            end else begin
               cx_in = cx_ff + shy;
               cy_in = cy_ff - shx;
               cz_in = cz_ff + atan_v;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = S_XMUL;
         end
         S_XMUL: begin
            mul_a    = 34'(dd);
            mul_b    = cs;
            state_in = S_YMUL;
         end
         S_YMUL: begin
            nx_in    = sat32(64'(prev_x_ff) + step_v[63:0]);
            mul_a    = 34'(dd);
            mul_b    = sn;
            state_in = S_YFIN;
         end
         S_YFIN: begin
            ny_in    = sat32(64'(prev_y_ff) + step_v[63:0]);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_x_in     = nx_ff;
               out_y_in     = ny_ff;
               out_h_in     = head_ff;
               out_t_in     = trav_ff;
               prev_x_in    = nx_ff;
               prev_y_in    = ny_ff;
               prev_d_in    = trav_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff   <= mul_a * mul_b;
      cnt_l_ff  <= cnt_l_in;
      cnt_r_ff  <= cnt_r_in;
      lo_ff     <= lo_in;
      acc_ff    <= acc_in;
      dist_l_ff <= dist_l_in;
      dist_r_ff <= dist_r_in;
      trav_ff   <= trav_in;
      head_ff   <= head_in;
      neg_ff    <= neg_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      flip_ff   <= flip_in;
      step_ff   <= step_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_h_ff  <= out_h_in;
      out_t_ff  <= out_t_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_d_ff    <= '0;
         radius_ff    <= RADIUS_RESET;
         track_ff     <= TRACK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_d_ff    <= prev_d_in;
         if (csr.valid && csr.index == REG_WHEEL_RADIUS) radius_ff <= csr.data;
         if (csr.valid && csr.index == REG_TRACK_WIDTH)  track_ff  <= csr.data;
      end
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign csr.ready     = 1'b1;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pos_x     = out_x_ff;
   assign rsp.pos_y     = out_y_ff;
   assign rsp.heading   = out_h_ff;
   assign rsp.travelled = out_t_ff;

endmodule

@@ sv/odo_div.sv @@
// ----------------------------------------------------------------------------
// odo_div - radix 2 restoring divider
// Divides a 48 bit numerator by a 16 bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module odo_div
   import odo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [15:0]    numer_hi,
   input  logic [31:0]    numer_lo,
   input  logic [15:0]    divisor,
   output div_status_type status,
   output logic [31:0]    quotient
);

   logic [15:0] rem_ff, rem_in;
   logic [31:0] sh_ff, sh_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic        ge;

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, sh_ff[31]};
      ge      = trial >= {1'b0, divisor};
      if (start) begin
         rem_in  = numer_hi;
         sh_in   = numer_lo;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         sh_in  = {sh_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = sh_ff;

endmodule

@@ sv/odo_checker.sv @@
// ----------------------------------------------------------------------------
// odo_checker - port level checks for the odometry block
// Watches request and response handshakes over time.
// ----------------------------------------------------------------------------
module odo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pos_x,
   input logic [31:0] rsp_pos_y
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in work");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid && !rsp_valid |=> !rsp_valid)
      else $error("response word without a request");

endmodule

bind differential_drive_odometry_top odo_checker u_odo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_pos_x (rsp.pos_x),
   .rsp_pos_y (rsp.pos_y)
);

@@ verif/differential_drive_odometry_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_checker - pose predictor and response checker
// Watches the request, response and register write channels, works out the
// expected pose word for every accepted request and compares each response
// word against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module differential_drive_odometry_checker
   import odo_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   odo_req_if        req_mon,
   odo_rsp_if        rsp_mon,
   odo_csr_if        csr_mon,
   output int        fail_count,
   output int        pending_count
);

   localparam logic MODE_CLEAR = 1'b1;
   localparam logic [63:0] DEG_TO_RAD = 64'd74961321;
   localparam logic [63:0] RAD_TO_DEG = 64'd3754936;
   localparam longint TURN_FULL = 64'sd23592960;
   localparam longint TURN_HALF = 64'sd11796480;
   localparam longint TURN_QUARTER = 64'sd5898240;
   localparam longint ROT_GAIN = 64'sd652032874;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] travelled;
   } pose_type;

   pose_type pose_q[$];
   logic [15:0] radius_cfg;
   logic [15:0] track_cfg;
   logic signed [31:0] last_x;
   logic signed [31:0] last_y;
   logic signed [31:0] last_dist;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint arc_angle(int i);
      logic [63:0] k;
      logic [63:0] t;
      logic [63:0] c;
      case (i)
         0: return 754974720;
         1: return 445687602;
         2: return 235489088;
         3: return 119537938;
         4: return 60000934;
         5: return 30029717;
         6: return 15018523;
         default: begin
            k = 64'd961263669 << 20;
            t = k >> i;
            c = (3 * i < 64) ? (k >> (3 * i)) / 3 : 64'd0;
            return longint'((t - c + (64'd1 << 19)) >> 20);
         end
      endcase
   endfunction

   function automatic longint wheel_travel(longint count, logic [15:0] radius);
      logic neg;
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] v;
      neg = count < 0;
      mag = neg ? -count : count;
      m = mag * {48'd0, radius};
      v = (m >> 32) * DEG_TO_RAD + (({32'd0, m[31:0]} * DEG_TO_RAD + 64'h80000000) >> 32);
      return neg ? -longint'(v) : longint'(v);
   endfunction

   function automatic logic signed [31:0] turn_deg(longint diff, logic [15:0] width);
      logic neg;
      logic [63:0] mag;
      logic [63:0] w;
      logic [63:0] q;
      longint d;
      neg = diff < 0;
      mag = neg ? -diff : diff;
      w = (width == 16'd0) ? 64'd1 : {48'd0, width};
      q = ((mag << 16) + (w >> 1)) / w;
      if (q >= (64'd1 << 32)) return neg ? 32'sh80000000 : 32'sh7fffffff;
      d = longint'((q * RAD_TO_DEG + (64'd1 << 15)) >> 16);
      return clamp32(neg ? -d : d);
   endfunction

   task automatic rotate(input logic signed [31:0] h, output longint cs, output longint sn);
      longint r;
      longint x;
      longint y;
      longint z;
      longint nx;
      logic flip;
      r = longint'(h) % TURN_FULL;
      x = ROT_GAIN;
      y = 0;
      flip = 1'b0;
      if (r < 0) r += TURN_FULL;
      if (r >= TURN_HALF) r -= TURN_FULL;
      if (r > TURN_QUARTER) begin
         r -= TURN_HALF;
         flip = 1'b1;
      end else if (r < -TURN_QUARTER) begin
         r += TURN_HALF;
         flip = 1'b1;
      end
      z = r * 256;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arc_angle(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arc_angle(i);
         end
         x = nx;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   task automatic predict_pose(input logic mode, input logic signed [31:0] lc,
                               input logic signed [31:0] rc);
      pose_type p;
      longint dl_w;
      longint dr_w;
      longint step;
      longint cs;
      longint sn;
      if (mode == MODE_CLEAR) begin
         last_x = 0;
         last_y = 0;
         last_dist = 0;
         p = '{0, 0, 0, 0};
      end else begin
         dl_w = wheel_travel(longint'(lc), radius_cfg);
         dr_w = wheel_travel(longint'(rc), radius_cfg);
         p.travelled = clamp32((dl_w + dr_w) / 2);
         p.heading = turn_deg(dr_w - dl_w, track_cfg);
         rotate(p.heading, cs, sn);
         step = longint'(p.travelled) - longint'(last_dist);
         p.pos_x = clamp32(longint'(last_x) + ((step * cs + (64'sd1 <<< 29)) >>> 30));
         p.pos_y = clamp32(longint'(last_y) + ((step * sn + (64'sd1 <<< 29)) >>> 30));
         last_x = p.pos_x;
         last_y = p.pos_y;
         last_dist = p.travelled;
      end
      pose_q.push_back(p);
   endtask

   task automatic check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      pose_type p;
      if (reset) begin
         radius_cfg = RADIUS_RESET;
         track_cfg = TRACK_RESET;
         last_x = 0;
         last_y = 0;
         last_dist = 0;
         pose_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_WHEEL_RADIUS) radius_cfg = csr_mon.data;
            else if (csr_mon.index == REG_TRACK_WIDTH) track_cfg = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready)
            predict_pose(req_mon.mode, req_mon.left_count, req_mon.right_count);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pose_q.size() == 0) begin
               $error("response word with no request pending");
               fail_count++;
            end else begin
               p = pose_q.pop_front();
               check_field("pos_x", p.pos_x, rsp_mon.pos_x);
               check_field("pos_y", p.pos_y, rsp_mon.pos_y);
               check_field("heading", p.heading, rsp_mon.heading);
               check_field("travelled", p.travelled, rsp_mon.travelled);
            end
         end
      end
      pending_count = pose_q.size();
   end

endmodule

@@ verif/differential_drive_odometry_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_top_tb - testbench of the odometry block
// Directed extremes and clears, then random wheel trajectories and noise
// under several radius and track settings and idle/stall patterns; checking
// is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_tb
   import odo_pkg::*;
;

   localparam logic MODE_MEASURE = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;
   localparam int   CYCLE_LIMIT  = 600000;
   localparam int   SETTLE       = 200;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycles;
   int   send_idle_pct;
   int   stall_pct;
   logic signed [31:0] cum_l;
   logic signed [31:0] cum_r;

   odo_req_if req ();
   odo_rsp_if rsp ();
   odo_csr_if csr ();

   differential_drive_odometry_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   differential_drive_odometry_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req),
      .rsp_mon       (rsp),
      .csr_mon       (csr),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) rsp.ready <= ($urandom_range(0, 99) >= stall_pct);

   task automatic send_word(logic mode, logic signed [31:0] lc, logic signed [31:0] rc);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.mode = mode;
      req.left_count = lc;
      req.right_count = rc;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [15:0] value);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data = value;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic random_phase(int n);
      int k;
      logic signed [31:0] dl;
      logic signed [31:0] dr;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 5) begin
            cum_l = 0;
            cum_r = 0;
            send_word(MODE_CLEAR, $urandom, $urandom);
         end else if (k < 25) begin
            send_word(MODE_MEASURE, $urandom, $urandom);
         end else begin
            // smooth trajectory: small wheel steps on top of the running angle
            dl = $signed($urandom_range(0, 2000)) - 1000;
            dr = (k < 60) ? dl + $signed($urandom_range(0, 200)) - 100
                          : $signed($urandom_range(0, 2000)) - 1000;
            cum_l += dl;
            cum_r += dr;
            send_word(MODE_MEASURE, cum_l, cum_r);
         end
         if (i == n / 2 && n > 10) drain();
      end
      drain();
   endtask

   initial begin
      cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      cum_l = 0;
      cum_r = 0;
      req.valid = 1'b0;
      req.mode = MODE_MEASURE;
      req.left_count = '0;
      req.right_count = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(MODE_MEASURE, 0, 0);
      send_word(MODE_MEASURE, 360, 360);
      send_word(MODE_MEASURE, 720, 900);
      send_word(MODE_MEASURE, -720, 720);
      send_word(MODE_CLEAR, 32'sh7fffffff, 32'sh80000000);
      send_word(MODE_MEASURE, 32'sh7fffffff, 32'sh7fffffff);
      send_word(MODE_MEASURE, 32'sh80000000, 32'sh80000000);
      send_word(MODE_MEASURE, 32'sh7fffffff, 32'sh80000000);
      send_word(MODE_MEASURE, 32'sh80000000, 32'sh7fffffff);
      send_word(MODE_MEASURE, -1, 1);
      send_word(MODE_MEASURE, 1, -1);
      send_word(MODE_CLEAR, 0, 0);
      send_word(MODE_MEASURE, 1000, 1500);
      send_word(MODE_MEASURE, 2000, 1000);
      drain();
      write_reg(REG_WHEEL_RADIUS, 16'hffff);
      write_reg(REG_TRACK_WIDTH, 16'd1);
      send_word(MODE_MEASURE, 32'sh7fffffff, 32'sh80000000);
      send_word(MODE_MEASURE, 100000, -100000);
      send_word(MODE_MEASURE, 32'sh7fffffff, 32'sh7fffffff);
      drain();
      write_reg(REG_WHEEL_RADIUS, 16'd1);
      write_reg(REG_TRACK_WIDTH, 16'hffff);
      send_word(MODE_MEASURE, 32'sh80000000, 32'sh7fffffff);
      send_word(MODE_MEASURE, 5, 9);
      send_word(MODE_CLEAR, -5, -9);
      drain();

      write_reg(REG_WHEEL_RADIUS, RADIUS_RESET);
      write_reg(REG_TRACK_WIDTH, TRACK_RESET);
      random_phase(110);

      send_idle_pct = 46;
      write_reg(REG_WHEEL_RADIUS, 16'hffff);
      write_reg(REG_TRACK_WIDTH, 16'hffff);
      random_phase(110);

      send_idle_pct = 0;
      stall_pct = 46;
      write_reg(REG_WHEEL_RADIUS, 16'd1);
      write_reg(REG_TRACK_WIDTH, 16'd1);
      random_phase(110);

      send_idle_pct = 28;
      stall_pct = 28;
      write_reg(REG_WHEEL_RADIUS, 16'($urandom_range(1, 65535)));
      write_reg(REG_TRACK_WIDTH, 16'($urandom_range(1, 65535)));
      random_phase(60);
      write_reg(REG_WHEEL_RADIUS, 16'd6554);
      write_reg(REG_TRACK_WIDTH, 16'd300);
      random_phase(60);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
